>>> sv/bsed_pkg.sv
// ----------------------------------------------------------------------------
// bsed_pkg: shared types and constants of the block stddev edge detector
// Field widths, register codes, reset values, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bsed_pkg;

	// default size limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_BLOCK  = 32;

	// field widths
	localparam int LUMA_W     = 8;
	localparam int SQ_W       = 2 * LUMA_W;
	localparam int SUM_W      = 18;
	localparam int SQSUM_W    = 27;
	localparam int THR_W      = 12;
	localparam int COUNT_W    = 21;
	localparam int IDX_OUT_W  = 10;
	localparam int FSIZE_W    = 11;
	localparam int BSIZE_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// stddev threshold is in 1/16 units, so variance scales by 16*16
	localparam int STD_SCALE_SHIFT = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// register reset values
	localparam logic [FSIZE_W-1:0] RST_FRAME_WIDTH  = 11'd320;
	localparam logic [FSIZE_W-1:0] RST_FRAME_HEIGHT = 11'd240;
	localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE   = 6'd10;
	localparam logic [THR_W-1:0]   RST_THRESHOLD    = 12'd640;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BLOCK_SIZE   = 2'd2,
		REG_THRESHOLD    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_DIFF,
		ST_CMP
	} ctrl_state_t;

	typedef struct packed {
		logic take;      // input beat accepted, read column accumulator
		logic acc;       // accumulate, write back, advance position
		logic mul;       // form products
		logic diff;      // form variance difference and threshold product
		logic load_out;  // compare and load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic block_end; // current pixel closes its block
		logic out_free;  // result register can take a new beat
	} dp_status_t;

endpackage

>>> sv/bsed_if.sv
// ----------------------------------------------------------------------------
// bsed_if: channel interfaces of the block stddev edge detector
// Pixel input, block result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bsed_pix_if import bsed_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LUMA_W-1:0] luma;
	logic              frame_start;

	modport source (output valid, output luma, output frame_start, input ready);
	modport sink   (input valid, input luma, input frame_start, output ready);
endinterface

interface bsed_blk_if import bsed_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] block_col;
	logic [IDX_OUT_W-1:0] block_row;
	logic                 detected;
	logic [COUNT_W-1:0]   detected_total;
	logic                 frame_done;

	modport source (output valid, output block_col, output block_row, output detected,
		output detected_total, output frame_done, input ready);
	modport sink   (input valid, input block_col, input block_row, input detected,
		input detected_total, input frame_done, output ready);
endinterface

interface bsed_cfg_if import bsed_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/block_stddev_edge_detect.sv
// ----------------------------------------------------------------------------
// block_stddev_edge_detect: block standard deviation detector
// Sequence: a taken pixel is read from and written back to its column
//   accumulator; a pixel that closes a block then steps through the product,
//   difference and compare states and waits for a free result register.
//   No new pixel is taken until the last one is through these steps.
// Reset: arst_n clears position, detect count and result valid and loads
//   the default sizes and threshold; the accumulator memory is not cleared.
// ----------------------------------------------------------------------------
module block_stddev_edge_detect import bsed_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
	input  logic       clk,
	input  logic       arst_n,
	bsed_pix_if.sink   pix,
	bsed_blk_if.source blk,
	bsed_cfg_if.sink   cfg
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int OW = $clog2(MAX_BLOCK);

	logic [XW:0]      width_lim;
	logic [YW:0]      height_lim;
	logic [OW:0]      block_lim;
	logic [THR_W-1:0] threshold;
	dp_cmd_t          cmd;
	dp_status_t       status;
	logic             in_ready;

	// configuration registers
	bsed_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_BLOCK  (MAX_BLOCK)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.width_lim  (width_lim),
		.height_lim (height_lim),
		.block_lim  (block_lim),
		.threshold  (threshold)
	);

	// sequencing
	bsed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign pix.ready = in_ready;

	// datapath
	bsed_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_BLOCK  (MAX_BLOCK)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.width_lim      (width_lim),
		.height_lim     (height_lim),
		.block_lim      (block_lim),
		.threshold      (threshold),
		.luma           (pix.luma),
		.frame_start    (pix.frame_start),
		.out_valid      (blk.valid),
		.out_ready      (blk.ready),
		.block_col      (blk.block_col),
		.block_row      (blk.block_row),
		.detected       (blk.detected),
		.detected_total (blk.detected_total),
		.frame_done     (blk.frame_done)
	);

endmodule

>>> sv/bsed_cfg_regs.sv
// ----------------------------------------------------------------------------
// bsed_cfg_regs: configuration registers
// Holds frame and block sizes and the threshold, and clamps the sizes to
// the range the datapath supports.
// ----------------------------------------------------------------------------
module bsed_cfg_regs import bsed_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT),
	localparam int OW = $clog2(MAX_BLOCK)
) (
	input  logic             clk,
	input  logic             arst_n,
	bsed_cfg_if.sink         cfg,
	output logic [XW:0]      width_lim,
	output logic [YW:0]      height_lim,
	output logic [OW:0]      block_lim,
	output logic [THR_W-1:0] threshold
);

	logic [FSIZE_W-1:0] frame_width_q;
	logic [FSIZE_W-1:0] frame_height_q;
	logic [BSIZE_W-1:0] block_size_q;
	logic [THR_W-1:0]   threshold_q;

	assign cfg.ready = 1'b1;

	// write the addressed register on each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			block_size_q   <= RST_BLOCK_SIZE;
			threshold_q    <= RST_THRESHOLD;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data[FSIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data[FSIZE_W-1:0];
				REG_BLOCK_SIZE:   block_size_q   <= cfg.data[BSIZE_W-1:0];
				REG_THRESHOLD:    threshold_q    <= cfg.data[THR_W-1:0];
			endcase
		end
	end

	// clamp sizes to 1..max
	always_comb begin
		if (frame_width_q == '0)
			width_lim = (XW+1)'(1);
		else if (int'(frame_width_q) > MAX_WIDTH)
			width_lim = (XW+1)'(MAX_WIDTH);
		else
			width_lim = (XW+1)'(frame_width_q);

		if (frame_height_q == '0)
			height_lim = (YW+1)'(1);
		else if (int'(frame_height_q) > MAX_HEIGHT)
			height_lim = (YW+1)'(MAX_HEIGHT);
		else
			height_lim = (YW+1)'(frame_height_q);

		if (block_size_q == '0)
			block_lim = (OW+1)'(1);
		else if (int'(block_size_q) > MAX_BLOCK)
			block_lim = (OW+1)'(MAX_BLOCK);
		else
			block_lim = (OW+1)'(block_size_q);
	end

	assign threshold = threshold_q;

endmodule

>>> sv/bsed_ctrl.sv
// ----------------------------------------------------------------------------
// bsed_ctrl: sequencing controller
// Takes one pixel, accumulates it, and on a block end steps the datapath
// through the product, difference and compare steps.
// ----------------------------------------------------------------------------
module bsed_ctrl import bsed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.block_end ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				// hold until the result register frees up
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> sv/bsed_datapath.sv
// ----------------------------------------------------------------------------
// bsed_datapath: position tracking, column accumulators and detect math
// Keeps raster position and block offsets, the per block column sum and
// sum of squares in a memory, and forms the variance test over three steps.
// ----------------------------------------------------------------------------
module bsed_datapath import bsed_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT),
	localparam int OW = $clog2(MAX_BLOCK)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic [XW:0]          width_lim,
	input  logic [YW:0]          height_lim,
	input  logic [OW:0]          block_lim,
	input  logic [THR_W-1:0]     threshold,
	input  logic [LUMA_W-1:0]    luma,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_OUT_W-1:0] block_col,
	output logic [IDX_OUT_W-1:0] block_row,
	output logic                 detected,
	output logic [COUNT_W-1:0]   detected_total,
	output logic                 frame_done
);

	localparam int NW  = 2 * (OW + 1);
	localparam int AW  = (NW + SQSUM_W > 2 * SUM_W) ? NW + SQSUM_W : 2 * SUM_W;
	localparam int RW  = 2 * THR_W + 2 * NW;
	localparam int LHW = AW + STD_SCALE_SHIFT;
	localparam int KW  = (LHW > RW) ? LHW : RW;
	localparam int MW  = SUM_W + SQSUM_W;

	// position state
	logic [XW-1:0]      px_q, bx_q;
	logic [YW-1:0]      py_q, by_q;
	logic [OW-1:0]      ox_q, oy_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;

	// payload registers
	logic [LUMA_W-1:0]  luma_q;
	logic [SQ_W-1:0]    sq_q;
	logic [MW-1:0]      rd_q;
	logic [SUM_W-1:0]   s1_q;
	logic [SQSUM_W-1:0] s2_q;
	logic [NW-1:0]      n_q;
	logic               frame_end_q;
	logic [XW-1:0]      blk_col_q;
	logic [YW-1:0]      blk_row_q;
	logic [AW-1:0]      a_q, b_q;
	logic [2*THR_W-1:0] tt_q;
	logic [2*NW-1:0]    nn_q;
	logic [AW-1:0]      diff_q;
	logic [RW-1:0]      rhs_q;
	logic [IDX_OUT_W-1:0] col_out_q, row_out_q;
	logic               det_out_q, done_out_q;
	logic [COUNT_W-1:0] total_out_q;

	logic [MW-1:0] acc_mem [MAX_WIDTH];

	logic [XW-1:0]      rd_col;
	logic [XW:0]        px_inc;
	logic [YW:0]        py_inc;
	logic [OW:0]        ox_inc, oy_inc;
	logic               first_px, end_row, end_ylim, end_frame, end_x, end_y;
	logic [SUM_W-1:0]   new_s1;
	logic [SQSUM_W-1:0] new_s2;
	logic [NW-1:0]      n_acc;
	logic [KW-1:0]      lhs_cmp, rhs_cmp;
	logic               det;
	logic [COUNT_W-1:0] count_next;

	// accumulate step: limits, block ends and new sums
	assign rd_col   = frame_start ? '0 : bx_q;
	assign px_inc   = {1'b0, px_q} + (XW+1)'(1);
	assign py_inc   = {1'b0, py_q} + (YW+1)'(1);
	assign ox_inc   = {1'b0, ox_q} + (OW+1)'(1);
	assign oy_inc   = {1'b0, oy_q} + (OW+1)'(1);
	assign first_px = (ox_q == '0) && (oy_q == '0);
	assign end_row  = px_inc >= width_lim;
	assign end_ylim = py_inc >= height_lim;
	assign end_frame = end_row && end_ylim;
	assign end_x    = end_row || (ox_inc >= block_lim);
	assign end_y    = end_ylim || (oy_inc >= block_lim);
	assign n_acc    = NW'(ox_inc) * NW'(oy_inc);

	assign new_s1 = first_px ? SUM_W'(luma_q) : rd_q[MW-1:SQSUM_W] + SUM_W'(luma_q);
	assign new_s2 = first_px ? SQSUM_W'(sq_q) : rd_q[SQSUM_W-1:0] + SQSUM_W'(sq_q);

	assign status.block_end = end_x && end_y;
	assign status.out_free  = !out_valid_q || out_ready;

	// compare step
	assign lhs_cmp    = KW'({diff_q, {STD_SCALE_SHIFT{1'b0}}});
	assign rhs_cmp    = KW'(rhs_q);
	assign det        = lhs_cmp > rhs_cmp;
	assign count_next = (det && count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;

	// column accumulator memory
	always_ff @(posedge clk) begin
		if (cmd.take)
			rd_q <= acc_mem[rd_col];
		if (cmd.acc)
			acc_mem[bx_q] <= {new_s1, new_s2};
	end

	// position, detect count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q        <= '0;
			py_q        <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take && frame_start) begin
				px_q    <= '0;
				py_q    <= '0;
				ox_q    <= '0;
				oy_q    <= '0;
				bx_q    <= '0;
				by_q    <= '0;
				count_q <= '0;
			end
			if (cmd.acc) begin
				if (end_frame) begin
					px_q <= '0;
					py_q <= '0;
					ox_q <= '0;
					oy_q <= '0;
					bx_q <= '0;
					by_q <= '0;
				end else if (end_row) begin
					px_q <= '0;
					ox_q <= '0;
					bx_q <= '0;
					py_q <= py_inc[YW-1:0];
					if (end_y) begin
						oy_q <= '0;
						by_q <= by_q + YW'(1);
					end else begin
						oy_q <= oy_inc[OW-1:0];
					end
				end else begin
					px_q <= px_inc[XW-1:0];
					if (end_x) begin
						ox_q <= '0;
						bx_q <= bx_q + XW'(1);
					end else begin
						ox_q <= ox_inc[OW-1:0];
					end
				end
			end
			if (cmd.load_out)
				count_q <= frame_end_q ? '0 : count_next;
			// hold the result until taken
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// staged arithmetic and result payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			luma_q <= luma;
			sq_q   <= SQ_W'(luma) * SQ_W'(luma);
		end
		if (cmd.acc) begin
			s1_q        <= new_s1;
			s2_q        <= new_s2;
			n_q         <= n_acc;
			frame_end_q <= end_frame;
			blk_col_q   <= bx_q;
			blk_row_q   <= by_q;
		end
		if (cmd.mul) begin
			a_q  <= AW'(n_q) * AW'(s2_q);
			b_q  <= AW'(s1_q) * AW'(s1_q);
			tt_q <= (2*THR_W)'(threshold) * (2*THR_W)'(threshold);
			nn_q <= (2*NW)'(n_q) * (2*NW)'(n_q);
		end
		if (cmd.diff) begin
			diff_q <= (a_q > b_q) ? a_q - b_q : '0;
			rhs_q  <= RW'(tt_q) * RW'(nn_q);
		end
		if (cmd.load_out) begin
			col_out_q   <= IDX_OUT_W'(blk_col_q);
			row_out_q   <= IDX_OUT_W'(blk_row_q);
			det_out_q   <= det;
			total_out_q <= count_next;
			done_out_q  <= frame_end_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign block_col      = col_out_q;
	assign block_row      = row_out_q;
	assign detected       = det_out_q;
	assign detected_total = total_out_q;
	assign frame_done     = done_out_q;

`ifndef SYNTHESIS
	// a result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// accumulation directly follows a taken pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> $past(cmd.take))
		else $error("accumulate without a taken pixel");

	// the last block of a frame restarts the detect count
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && frame_end_q) |=> (count_q == '0))
		else $error("detect count not cleared at frame end");

	// block index and offsets never run ahead of the pixel position
	assert property (@(posedge clk) disable iff (!arst_n)
		(bx_q <= px_q) && (ox_q <= px_q) && (by_q <= py_q) && (oy_q <= py_q))
		else $error("block position ahead of pixel position");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the block stddev edge detector
// Streams raster frames through the pixel channel under several size and
// threshold settings, predicts each block result in the bench, checks every
// result beat field by field, in order. Both idle at random for 2/3 of the run.
// ----------------------------------------------------------------------------
module tb_top;
	import bsed_pkg::*;

	localparam int unsigned ITEM_TARGET  = 1900;
	localparam int unsigned PHASE_ITEMS  = 80;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT  = 500_000;
	localparam int unsigned PRINT_LIMIT  = 200;

	// directed frame: 5x3 pixels, 2x2 blocks, then a wrapped frame and restarts
	localparam logic [25*8-1:0] DIRECTED_LUMA = {
		8'd255, 8'd255, 8'd0,   8'd255, 8'd7,
		8'd255, 8'd255, 8'd0,   8'd0,   8'd200,
		8'd1,   8'd2,   8'd3,   8'd3,   8'd128,
		8'd10,  8'd20,  8'd30,
		8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0, 8'd255
	};
	localparam logic [24:0] DIRECTED_START = 25'h0440000;

	typedef struct packed {
		logic [LUMA_W-1:0] luma;
		logic              start;
	} pixel_beat_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] col;
		logic [IDX_OUT_W-1:0] row;
		logic                 det;
		logic [COUNT_W-1:0]   total;
		logic                 done;
	} block_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// channel drive, known from time zero
	logic                  pix_valid = 1'b0;
	logic [LUMA_W-1:0]     pix_luma  = '0;
	logic                  pix_start = 1'b0;
	logic                  blk_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	cfg_reg_t              cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bsed_pix_if pix_ch ();
	bsed_blk_if blk_ch ();
	bsed_cfg_if cfg_ch ();

	assign pix_ch.valid       = pix_valid;
	assign pix_ch.luma        = pix_luma;
	assign pix_ch.frame_start = pix_start;
	assign blk_ch.ready       = blk_ready;
	assign cfg_ch.valid       = cfg_valid;
	assign cfg_ch.index       = cfg_index;
	assign cfg_ch.data        = cfg_data;

	block_stddev_edge_detect dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.blk    (blk_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of the registers
	logic [FSIZE_W-1:0] reg_width  = RST_FRAME_WIDTH;
	logic [FSIZE_W-1:0] reg_height = RST_FRAME_HEIGHT;
	logic [BSIZE_W-1:0] reg_block  = RST_BLOCK_SIZE;
	logic [THR_W-1:0]   reg_thresh = RST_THRESHOLD;

	// predictor copy of the scan position and column accumulators
	logic [SUM_W-1:0]   acc_sum [DEF_MAX_WIDTH];
	logic [SQSUM_W-1:0] acc_sq  [DEF_MAX_WIDTH];
	int unsigned        pos_x = 0, pos_y = 0;
	int unsigned        in_blk_x = 0, in_blk_y = 0;
	int unsigned        blk_col_idx = 0, blk_row_idx = 0;
	logic [COUNT_W-1:0] det_count = '0;

	pixel_beat_t   pixel_q [$];
	block_result_t pending_blocks [$];
	int unsigned   items_queued   = 0;
	int unsigned   pixels_taken   = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count    = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// sender and receiver idle rates over the three thirds of the run
	function automatic int unsigned idle_pct(input bit receiver);
		if (pixels_taken < ITEM_TARGET / 3)
			return receiver ? 59 : 21;
		if (pixels_taken < 2 * ITEM_TARGET / 3)
			return receiver ? 21 : 59;
		return 0;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void clear_scan();
		pos_x       = 0;
		pos_y       = 0;
		in_blk_x    = 0;
		in_blk_y    = 0;
		blk_col_idx = 0;
		blk_row_idx = 0;
		det_count   = '0;
	endfunction

	// take one pixel, queue the block result it closes, if any
	function automatic void step_detector(input logic [LUMA_W-1:0] luma, input logic start);
		int unsigned       w, h, bs, col;
		bit                end_row, end_frame, end_x, end_y, det;
		longint unsigned   n, s1, s2, a, b, lhs, rhs, t;
		block_result_t     res;
		w  = clamp_size(reg_width, DEF_MAX_WIDTH);
		h  = clamp_size(reg_height, DEF_MAX_HEIGHT);
		bs = clamp_size(reg_block, DEF_MAX_BLOCK);
		if (start)
			clear_scan();
		col = (blk_col_idx < DEF_MAX_WIDTH) ? blk_col_idx : DEF_MAX_WIDTH - 1;

		// first pixel of a block loads the column, the rest accumulate
		if (in_blk_x == 0 && in_blk_y == 0) begin
			acc_sum[col] = SUM_W'(luma);
			acc_sq[col]  = SQSUM_W'(luma) * SQSUM_W'(luma);
		end else begin
			acc_sum[col] = acc_sum[col] + SUM_W'(luma);
			acc_sq[col]  = acc_sq[col] + SQSUM_W'(luma) * SQSUM_W'(luma);
		end

		end_row   = pos_x + 1 >= w;
		end_frame = end_row && (pos_y + 1 >= h);
		end_x     = end_row || (in_blk_x + 1 >= bs);
		end_y     = (pos_y + 1 >= h) || (in_blk_y + 1 >= bs);

		// variance test scaled to integers: 256*(n*S2 - S1^2) > T^2 * n^2
		if (end_x && end_y) begin
			n   = longint'(in_blk_x + 1) * longint'(in_blk_y + 1);
			s1  = acc_sum[col];
			s2  = acc_sq[col];
			t   = reg_thresh;
			a   = n * s2;
			b   = s1 * s1;
			lhs = (a > b) ? (a - b) * 256 : 0;
			rhs = t * t * n * n;
			det = lhs > rhs;
			if (det && det_count != COUNT_MAX)
				det_count++;
			res.col   = blk_col_idx[IDX_OUT_W-1:0];
			res.row   = blk_row_idx[IDX_OUT_W-1:0];
			res.det   = det;
			res.total = det_count;
			res.done  = end_frame;
			pending_blocks.push_back(res);
		end

		// advance the scan position
		if (end_frame) begin
			clear_scan();
		end else if (end_row) begin
			pos_x       = 0;
			in_blk_x    = 0;
			blk_col_idx = 0;
			pos_y++;
			if (end_y) begin
				in_blk_y = 0;
				blk_row_idx++;
			end else begin
				in_blk_y++;
			end
		end else begin
			pos_x++;
			if (end_x) begin
				in_blk_x = 0;
				blk_col_idx++;
			end else begin
				in_blk_x++;
			end
		end
	endfunction

	// pixel driver: hold a beat until taken, then pull the next one or idle
	always @(posedge clk) begin : drive_pixels
		pixel_beat_t next_px;
		if (arst_n) begin
			if (pix_valid && pix_ch.ready) begin
				step_detector(pix_luma, pix_start);
				pixels_taken++;
			end
			if (!pix_valid || pix_ch.ready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					next_px   = pixel_q.pop_front();
					pix_valid <= 1'b1;
					pix_luma  <= next_px.luma;
					pix_start <= next_px.start;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each beat with the oldest predicted block
	always @(posedge clk) begin : check_blocks
		block_result_t got, want;
		if (arst_n) begin
			if (blk_ready && blk_ch.valid) begin
				got.col   = blk_ch.block_col;
				got.row   = blk_ch.block_row;
				got.det   = blk_ch.detected;
				got.total = blk_ch.detected_total;
				got.done  = blk_ch.frame_done;
				if (pending_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected block beat col %0d row %0d",
						got.col, got.row));
				end else begin
					want = pending_blocks.pop_front();
					if (got.col !== want.col)
						report_mismatch($sformatf("block_col got %0d want %0d",
							got.col, want.col));
					if (got.row !== want.row)
						report_mismatch($sformatf("block_row got %0d want %0d",
							got.row, want.row));
					if (got.det !== want.det)
						report_mismatch($sformatf("detected got %0b want %0b at block %0d,%0d",
							got.det, want.det, want.col, want.row));
					if (got.total !== want.total)
						report_mismatch($sformatf("detected_total got %0d want %0d at block %0d,%0d",
							got.total, want.total, want.col, want.row));
					if (got.done !== want.done)
						report_mismatch($sformatf("frame_done got %0b want %0b at block %0d,%0d",
							got.done, want.done, want.col, want.row));
				end
			end
			blk_ready <= ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** block_stddev_edge_detect: FAILED **");
			$finish;
		end
	end

	// write one register while the block is idle, then mirror it
	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  reg_width  = value[FSIZE_W-1:0];
			REG_FRAME_HEIGHT: reg_height = value[FSIZE_W-1:0];
			REG_BLOCK_SIZE:   reg_block  = value[BSIZE_W-1:0];
			REG_THRESHOLD:    reg_thresh = value[THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int unsigned w, input int unsigned h,
			input int unsigned bs, input int unsigned thr);
		write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
		write_register(REG_BLOCK_SIZE, CFG_DATA_W'(bs));
		write_register(REG_THRESHOLD, CFG_DATA_W'(thr));
	endtask

	// wait until every pixel is taken and every block has come out, then settle
	task automatic wait_drained();
		while (pixel_q.size() != 0 || pix_valid || pending_blocks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// queue one frame at the current sizes; some frames are cut short or restarted
	task automatic queue_frame(input bit with_start, input int unsigned cap,
			output bit complete);
		int unsigned w, h, total, mode, base, spread, stray_at;
		int          v;
		pixel_beat_t beat;
		w        = clamp_size(reg_width, DEF_MAX_WIDTH);
		h        = clamp_size(reg_height, DEF_MAX_HEIGHT);
		total    = w * h;
		complete = 1'b1;
		if (total > cap) begin
			total    = cap;
			complete = 1'b0;
		end
		if ($urandom_range(7) == 0 && total > 1) begin
			total    = $urandom_range(1, total - 1);
			complete = 1'b0;
		end
		stray_at = ($urandom_range(9) == 0 && total > 2) ? $urandom_range(1, total - 1) : 0;
		if (stray_at != 0)
			complete = 1'b0;
		mode   = $urandom_range(3);
		base   = $urandom_range(255);
		spread = $urandom_range(1, 24);
		for (int unsigned i = 0; i < total; i++) begin
			case (mode)
				0: v = $urandom_range(255);
				1: v = int'(base) + int'($urandom_range(2 * spread)) - int'(spread);
				2: v = base;
				default: v = $urandom_range(1) ? 255 : 0;
			endcase
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			beat.luma  = LUMA_W'(v);
			beat.start = (i == 0 && with_start) || (stray_at != 0 && i == stray_at);
			pixel_q.push_back(beat);
		end
		items_queued += total;
	endtask

	initial begin : stimulus
		int unsigned phase, phase_target, cap, w, h, bs, thr, r;
		bit          frame_ok, single_frame;
		pixel_beat_t beat;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: clipped blocks, flat and mixed blocks, wrap and restarts
		write_all(5, 3, 2, 0);
		for (int i = 0; i < 25; i++) begin
			beat.luma  = DIRECTED_LUMA[(24 - i) * 8 +: 8];
			beat.start = DIRECTED_START[i];
			pixel_q.push_back(beat);
		end
		items_queued = 25;

		// random phases, each with its own sizes and threshold
		phase = 0;
		while (items_queued < ITEM_TARGET) begin
			wait_drained();
			r = $urandom_range(9);
			w = $urandom_range(0, 24);
			h = $urandom_range(0, 12);
			bs = (r < 7) ? $urandom_range(1, 6) :
				(r == 7) ? $urandom_range(7, 32) : $urandom_range(33, 63);
			r = $urandom_range(7);
			thr = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 1600);
			cap = 32'hFFFF_FFFF;
			case (phase)
				1: begin
					// widest row, single row, largest block: saturate all three
					w   = 2047;
					h   = 0;
					bs  = 63;
				end
				3: begin
					// one pixel wide, tallest frame, cut after a few block rows
					w   = 0;
					h   = 2047;
					bs  = 32;
					cap = 120;
				end
				5: begin
					bs  = 0;
					thr = 4095;
				end
				default: ;
			endcase
			write_all(w, h, bs, thr);
			single_frame = (phase == 1 || phase == 3);
			phase_target = items_queued + PHASE_ITEMS;
			frame_ok     = 1'b0;
			do begin
				queue_frame(!frame_ok || $urandom_range(3) != 0, cap, frame_ok);
			end while (!single_frame && items_queued < phase_target
				&& items_queued < ITEM_TARGET);
			phase++;
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("** block_stddev_edge_detect: PASSED **");
		else
			$display("** block_stddev_edge_detect: FAILED **");
		$finish;
	end

endmodule

>>> files.f
sv/bsed_pkg.sv
sv/bsed_if.sv
sv/bsed_cfg_regs.sv
sv/bsed_ctrl.sv
sv/bsed_datapath.sv
sv/block_stddev_edge_detect.sv
tb/tb_top.sv
